@@ sv/int64_microop_accumulator_core_assert.svh @@
// ----------------------------------------------------------------------------
// int64 micro-op accumulator assertion macros
// Concurrent property wrappers, all clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INT64_MICROOP_ACCUMULATOR_CORE_ASSERT_SVH
`define INT64_MICROOP_ACCUMULATOR_CORE_ASSERT_SVH

// cond must never hold
`define I64ACC_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define I64ACC_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ sv/i64acc_pkg.sv @@
// ----------------------------------------------------------------------------
// i64acc_pkg
// Shared types and codes of the int64 micro-op accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i64acc_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned StepCntW = $clog2(DataW);

  // operation codes
  localparam logic [3:0] OP_BEGIN = 4'd0;
  localparam logic [3:0] OP_SET   = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_SUB   = 4'd3;
  localparam logic [3:0] OP_MUL   = 4'd4;
  localparam logic [3:0] OP_DIV   = 4'd5;
  localparam logic [3:0] OP_MOD   = 4'd6;
  localparam logic [3:0] OP_AND   = 4'd7;
  localparam logic [3:0] OP_OR    = 4'd8;
  localparam logic [3:0] OP_XOR   = 4'd9;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BADOP   = 2'd1;
  localparam logic [1:0] STAT_DIVZERO = 2'd2;

  typedef struct packed {
    logic [3:0]               op;
    logic signed [DataW-1:0]  operand;
    logic [3:0]               old_size;
    logic                     last;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataW-1:0]  value;
    logic [1:0]               status;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

endpackage

@@ sv/int64_microop_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// int64_microop_accumulator_core
// Applies a stream of 64-bit update operations to one accumulator.
// ----------------------------------------------------------------------------
// One item at a time. Begin, set, add, sub, and, or, xor, wrong-type items,
// div and mod by zero, and items dropped after an error leave the core ready
// again in the next cycle. Mul, and div and mod by a nonzero operand, run on a
// shared bit-serial unit, one bit per cycle, and hold input ready low until it
// is done. An item marked last also passes through ST_EMIT to load the output
// register, and waits there while an earlier result is still untaken.
// A pending result on the output does not block items without last.
`timescale 1ns / 1ps

module int64_microop_accumulator_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  i64acc_pkg::in_beat_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output i64acc_pkg::out_beat_t  out_data_o
);

  `include "int64_microop_accumulator_core_assert.svh"

  localparam int unsigned W = i64acc_pkg::DataW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [W-1:0]           acc_q, acc_d;
  logic [1:0]             err_q, err_d;
  logic                   last_q, last_d;
  logic                   is_mod_q, is_mod_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  i64acc_pkg::out_beat_t  out_data_q, out_data_d;

  i64acc_pkg::alu_req_t   alu_req;
  i64acc_pkg::alu_rsp_t   alu_rsp;
  logic [W-1:0]           alu_a, alu_b, alu_lo, alu_rem;

  logic [W-1:0]           opnd, acc_mag, opnd_mag, begin_val, div_res;
  logic                   acc_neg, opnd_neg;
  state_e                 after_st;

  assign opnd     = $unsigned(in_data_i.operand);
  assign acc_neg  = acc_q[W-1];
  assign opnd_neg = opnd[W-1];
  assign acc_mag  = acc_neg ? (~acc_q + 1'b1) : acc_q;
  assign opnd_mag = opnd_neg ? (~opnd + 1'b1) : opnd;
  assign div_res  = is_mod_q ? alu_rem : alu_lo;

  // keep the low old_size bytes, eight or more keeps all
  always_comb begin
    for (int k = 0; k < W / 8; k++) begin
      if (in_data_i.old_size > 4'(k)) begin
        begin_val[8*k +: 8] = opnd[8*k +: 8];
      end else begin
        begin_val[8*k +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    err_d       = err_q;
    last_d      = last_q;
    is_mod_d    = is_mod_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    alu_req     = '0;
    alu_a       = '0;
    alu_b       = '0;
    after_st    = last_q ? ST_EMIT : ST_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          last_d   = in_data_i.last;
          after_st = in_data_i.last ? ST_EMIT : ST_IDLE;
          state_d  = after_st;
          if (in_data_i.op == i64acc_pkg::OP_BEGIN) begin
            acc_d = begin_val;
            err_d = i64acc_pkg::STAT_OK;
          end else if (err_q == i64acc_pkg::STAT_OK) begin
            case (in_data_i.op)
              i64acc_pkg::OP_SET: acc_d = opnd;
              i64acc_pkg::OP_ADD: acc_d = acc_q + opnd;
              i64acc_pkg::OP_SUB: acc_d = acc_q - opnd;
              i64acc_pkg::OP_AND: acc_d = acc_q & opnd;
              i64acc_pkg::OP_OR:  acc_d = acc_q | opnd;
              i64acc_pkg::OP_XOR: acc_d = acc_q ^ opnd;
              i64acc_pkg::OP_MUL: begin
                alu_req.start  = 1'b1;
                alu_req.is_div = 1'b0;
                alu_a          = acc_q;
                alu_b          = opnd;
                state_d        = ST_MUL;
              end
              i64acc_pkg::OP_DIV, i64acc_pkg::OP_MOD: begin
                if (opnd == '0) begin
                  err_d = i64acc_pkg::STAT_DIVZERO;
                end else begin
                  alu_req.start  = 1'b1;
                  alu_req.is_div = 1'b1;
                  alu_a          = acc_mag;
                  alu_b          = opnd_mag;
                  is_mod_d       = (in_data_i.op == i64acc_pkg::OP_MOD);
                  // remainder follows the dividend, quotient the sign mix
                  neg_d          = (in_data_i.op == i64acc_pkg::OP_MOD) ? acc_neg
                                                                        : acc_neg ^ opnd_neg;
                  state_d        = ST_DIV;
                end
              end
              default: err_d = i64acc_pkg::STAT_BADOP;
            endcase
          end
        end
      end
      ST_MUL: begin
        if (alu_rsp.done) begin
          acc_d   = alu_lo;
          state_d = after_st;
        end
      end
      ST_DIV: begin
        if (alu_rsp.done) begin
          acc_d   = neg_q ? (~div_res + 1'b1) : div_res;
          state_d = after_st;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_data_d.value  = (err_q == i64acc_pkg::STAT_OK) ? $signed(acc_q) : '0;
          out_data_d.status = err_q;
          acc_d             = '0;
          err_d             = i64acc_pkg::STAT_OK;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      err_q       <= i64acc_pkg::STAT_OK;
      last_q      <= 1'b0;
      is_mod_q    <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      err_q       <= err_d;
      last_q      <= last_d;
      is_mod_q    <= is_mod_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  i64acc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .rsp_o  (alu_rsp),
    .lo_o   (alu_lo),
    .rem_o  (alu_rem)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `I64ACC_ASSERT_IMPLIES(a_err_value_zero, out_valid_o && (out_data_o.status != i64acc_pkg::STAT_OK), out_data_o.value == '0, "error result carries nonzero value")
  `I64ACC_ASSERT_NEVER(a_busy_not_ready, alu_rsp.busy && in_ready_o, "input ready while shared unit busy")
  `I64ACC_ASSERT_IMPLIES(a_done_in_wait, alu_rsp.done, (state_q == ST_MUL) || (state_q == ST_DIV), "unit finished outside a wait state")

endmodule

@@ sv/i64acc_alu.sv @@
// ----------------------------------------------------------------------------
// i64acc_alu
// Bit-serial shift-add multiplier and restoring divider on one shared adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i64acc_alu (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  i64acc_pkg::alu_req_t           req_i,
  input  logic [i64acc_pkg::DataW-1:0]   a_i,
  input  logic [i64acc_pkg::DataW-1:0]   b_i,
  output i64acc_pkg::alu_rsp_t           rsp_o,
  output logic [i64acc_pkg::DataW-1:0]   lo_o,
  output logic [i64acc_pkg::DataW-1:0]   rem_o
);

  localparam int unsigned W = i64acc_pkg::DataW;

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic                           div_q;
  logic [i64acc_pkg::StepCntW-1:0] cnt_q, cnt_d;
  // mul: x multiplicand, y multiplier, r product
  // div: x dividend/quotient, y divisor, r remainder
  logic [W-1:0] x_q, x_d, y_q, y_d, r_q, r_d;

  logic [W-1:0] rem_sh;
  logic [W:0]   add_a, add_b, sum;
  logic         add_cin;

  assign rem_sh = {r_q[W-2:0], x_q[W-1]};

  // the one shared adder
  always_comb begin
    if (div_q) begin
      add_a   = {1'b0, rem_sh};
      add_b   = ~{1'b0, y_q};
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, r_q};
      add_b   = y_q[0] ? {1'b0, x_q} : '0;
      add_cin = 1'b0;
    end
    sum = add_a + add_b + {{W{1'b0}}, add_cin};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    r_d    = r_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = a_i;
      y_d    = b_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (div_q) begin
        // no borrow means the divisor fits
        if (!sum[W]) begin
          r_d = sum[W-1:0];
        end else begin
          r_d = rem_sh;
        end
        x_d = {x_q[W-2:0], ~sum[W]};
      end else begin
        r_d = sum[W-1:0];
        x_d = {x_q[W-2:0], 1'b0};
        y_d = {1'b0, y_q[W-1:1]};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == i64acc_pkg::StepCntW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      if (req_i.start) begin
        div_q <= req_i.is_div;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    r_q <= r_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign lo_o       = div_q ? x_q : r_q;
  assign rem_o      = r_q;

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for int64_microop_accumulator_core: directed corner
// cases, then random op sequences, scored against table results or a local
// predictor of the accumulator, with random idle and stall bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RandBeats  = 1770;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 100;

  // op codes with no package name
  localparam logic [3:0] OpWrongType   = 4'd10;
  localparam logic [3:0] OpUnusedFirst = 4'd11;
  localparam logic [3:0] OpUnusedLast  = 4'd15;

  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] AllOnes = '1;

  typedef struct {
    i64acc_pkg::in_beat_t  beat;
    bit                    typed;
    i64acc_pkg::out_beat_t want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  i64acc_pkg::in_beat_t  in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  i64acc_pkg::out_beat_t out_data_o;

  // predictor state
  logic [63:0] acc_q;
  logic [1:0]  err_q;

  i64acc_pkg::out_beat_t pending_results[$];
  stim_row_t             directed_rows[$];

  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  bit          calm_tail = 1'b0;

  int64_microop_accumulator_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic logic [63:0] magn(input logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  // one beat through the accumulator; emits is set when a result leaves
  task automatic apply_microop(input i64acc_pkg::in_beat_t b, output bit emits,
                               output i64acc_pkg::out_beat_t res);
    logic [63:0] opnd;
    logic [63:0] q;
    int unsigned n;
    opnd = b.operand;
    emits = 1'b0;
    res = '0;
    if (b.op == i64acc_pkg::OP_BEGIN) begin
      n = (b.old_size > 4'd8) ? 8 : b.old_size;
      acc_q = (n == 8) ? opnd : (opnd & ((64'd1 << (8 * n)) - 64'd1));
      err_q = i64acc_pkg::STAT_OK;
    end else if (err_q == i64acc_pkg::STAT_OK) begin
      case (b.op)
        i64acc_pkg::OP_SET: acc_q = opnd;
        i64acc_pkg::OP_ADD: acc_q = acc_q + opnd;
        i64acc_pkg::OP_SUB: acc_q = acc_q - opnd;
        i64acc_pkg::OP_MUL: acc_q = acc_q * opnd;
        i64acc_pkg::OP_DIV: begin
          if (opnd == 64'd0) begin
            err_q = i64acc_pkg::STAT_DIVZERO;
          end else begin
            q = magn(acc_q) / magn(opnd);
            acc_q = (acc_q[63] != opnd[63]) ? -q : q;
          end
        end
        i64acc_pkg::OP_MOD: begin
          if (opnd == 64'd0) begin
            err_q = i64acc_pkg::STAT_DIVZERO;
          end else begin
            q = magn(acc_q) % magn(opnd);
            acc_q = acc_q[63] ? -q : q;
          end
        end
        i64acc_pkg::OP_AND: acc_q = acc_q & opnd;
        i64acc_pkg::OP_OR:  acc_q = acc_q | opnd;
        i64acc_pkg::OP_XOR: acc_q = acc_q ^ opnd;
        default: err_q = i64acc_pkg::STAT_BADOP;
      endcase
    end
    if (b.last) begin
      emits = 1'b1;
      res.value = (err_q == i64acc_pkg::STAT_OK) ? acc_q : 64'd0;
      res.status = err_q;
      acc_q = '0;
      err_q = i64acc_pkg::STAT_OK;
    end
  endtask

  function automatic stim_row_t mk_row(input logic [3:0] op, input logic [63:0] operand,
                                       input logic [3:0] sz, input logic last,
                                       input bit typed, input logic [63:0] v,
                                       input logic [1:0] st);
    stim_row_t r;
    r.beat.op = op;
    r.beat.operand = operand;
    r.beat.old_size = sz;
    r.beat.last = last;
    r.typed = typed;
    r.want.value = v;
    r.want.status = st;
    return r;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = {$urandom, $urandom};
      4, 5: begin
        v = $urandom_range(0, 40);
        v = v - 64'd20;
      end
      6: v = MinVal;
      7: v = MaxVal;
      8: begin
        v = $urandom_range(0, 2);
        v = v - 64'd1;
      end
      default: v = 64'd1 << $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  function automatic logic [3:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 92) return 4'($urandom_range(i64acc_pkg::OP_SET, i64acc_pkg::OP_XOR));
    if (r < 96) return OpWrongType;
    return 4'($urandom_range(OpUnusedFirst, OpUnusedLast));
  endfunction

  // drive one beat, wait for the handshake, then predict
  task automatic send_beat(input i64acc_pkg::in_beat_t b, input bit typed,
                           input i64acc_pkg::out_beat_t want);
    bit emits;
    i64acc_pkg::out_beat_t res;
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    apply_microop(b, emits, res);
    if (emits) pending_results.push_back(typed ? want : res);
    beats_sent++;
  endtask

  // result scoreboard
  always @(posedge clk_i) begin : score_blk
    i64acc_pkg::out_beat_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result %h/%0d with nothing pending",
                                out_data_o.value, out_data_o.status));
      end else begin
        w = pending_results.pop_front();
        if (out_data_o.value !== w.value)
          flag_mismatch($sformatf("value %h, want %h", out_data_o.value, w.value));
        if (out_data_o.status !== w.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_data_o.status, w.status));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("** int64_microop_accumulator_core: FAILED **");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin : ready_gen
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 7)) @(posedge clk_i);
    end
  end

  initial begin : main_seq
    i64acc_pkg::in_beat_t b;
    int unsigned len;
    int unsigned num_directed;
    acc_q = '0;
    err_q = i64acc_pkg::STAT_OK;

    directed_rows.push_back(mk_row(i64acc_pkg::OP_ADD, 64'd0, 4'd0, 1'b1, 1, 64'd0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_BEGIN, MaxVal, 4'd8, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_ADD, 64'd1, 4'd0, 1'b1, 1, MinVal,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_BEGIN, AllOnes, 4'd0, 1'b1, 1, 64'd0,
                                   i64acc_pkg::STAT_OK));
    // size above eight takes all bytes
    directed_rows.push_back(mk_row(i64acc_pkg::OP_BEGIN, 64'h0123_4567_89ab_cdef, 4'd15,
                                   1'b1, 1, 64'h0123_4567_89ab_cdef, i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_BEGIN, AllOnes, 4'd3, 1'b1, 1,
                                   64'hff_ffff, i64acc_pkg::STAT_OK));
    // min / -1 wraps, min % -1 is zero
    directed_rows.push_back(mk_row(i64acc_pkg::OP_SET, MinVal, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_DIV, AllOnes, 4'd0, 1'b1, 1, MinVal,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_SET, MinVal, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_MOD, AllOnes, 4'd0, 1'b1, 1, 64'd0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_SET, 64'd5, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_DIV, 64'd0, 4'd0, 1'b1, 1, 64'd0,
                                   i64acc_pkg::STAT_DIVZERO));
    directed_rows.push_back(mk_row(OpWrongType, 64'd0, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_ADD, 64'd3, 4'd0, 1'b1, 1, 64'd0,
                                   i64acc_pkg::STAT_BADOP));
    directed_rows.push_back(mk_row(OpUnusedLast, AllOnes, 4'd15, 1'b1, 1, 64'd0,
                                   i64acc_pkg::STAT_BADOP));
    // first error sticks
    directed_rows.push_back(mk_row(i64acc_pkg::OP_SET, 64'd7, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_MOD, 64'd0, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(OpWrongType, 64'd0, 4'd0, 1'b1, 1, 64'd0,
                                   i64acc_pkg::STAT_DIVZERO));
    // begin mid-sequence clears the error
    directed_rows.push_back(mk_row(OpWrongType, 64'd0, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_BEGIN, 64'h1234_5678, 4'd2, 1'b1, 1,
                                   64'h5678, i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_SET, -64'd7, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_DIV, 64'd2, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_MOD, 64'd2, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_SUB, MinVal, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_MUL, MaxVal, 4'd0, 1'b0, 0, '0,
                                   i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_OR, 64'hf0f0_f0f0_0000_ffff, 4'd0, 1'b0,
                                   0, '0, i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_AND, 64'h0ff0_0ff0_ffff_00ff, 4'd0, 1'b0,
                                   0, '0, i64acc_pkg::STAT_OK));
    directed_rows.push_back(mk_row(i64acc_pkg::OP_XOR, 64'ha5a5_5a5a_c3c3_3c3c, 4'd0, 1'b1,
                                   0, '0, i64acc_pkg::STAT_OK));
    num_directed = directed_rows.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    while (beats_sent < num_directed + RandBeats) begin
      if (beats_sent > num_directed + (RandBeats * 85) / 100) calm_tail = 1'b1;
      if ($urandom_range(0, 9) < 8) begin
        // well-formed sequence: begin, a few ops, last on the final one
        len = $urandom_range(0, 6);
        b.op = i64acc_pkg::OP_BEGIN;
        b.operand = rand_operand();
        b.old_size = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
        b.last = (len == 0);
        send_beat(b, 0, '0);
        for (int unsigned k = 0; k < len; k++) begin
          b.op = pick_op();
          if ((b.op == i64acc_pkg::OP_DIV || b.op == i64acc_pkg::OP_MOD) &&
              $urandom_range(0, 9) == 0)
            b.operand = 64'd0;
          else
            b.operand = rand_operand();
          b.old_size = 4'($urandom);
          b.last = (k == len - 1);
          send_beat(b, 0, '0);
        end
      end else begin
        // noise: anything at all
        b.op = 4'($urandom);
        b.operand = rand_operand();
        b.old_size = 4'($urandom);
        b.last = 1'($urandom);
        send_beat(b, 0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d input beats (%0d from the directed table) and %0d results",
             beats_sent, num_directed, results_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("** int64_microop_accumulator_core: PASSED **");
    end else begin
      $display("** int64_microop_accumulator_core: FAILED **");
    end
    $finish;
  end

endmodule
